// ===== rtl/core/machine_csr_file_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the machine CSR file
// Concurrent checks, clocked and disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef MACHINE_CSR_FILE_ASSERT_SVH
`define MACHINE_CSR_FILE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset
`define MCSR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("machine_csr_file: check failed");

// Consequent must hold in the cycle after the antecedent
`define MCSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("machine_csr_file: check failed");

`else

`define MCSR_ASSERT(lbl, clk, rst_n, prop)
`define MCSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/mcsr_pkg.sv =====
// ----------------------------------------------------------------------------
// Machine CSR file package
// Addresses, legalization masks, register indexes and transaction types.
// ----------------------------------------------------------------------------
package mcsr_pkg;

  localparam int unsigned XLen      = 32;
  localparam int unsigned AddrW     = 12;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned StatusW   = 13;
  localparam int unsigned EnableW   = 12;
  localparam int unsigned InTdataW  = 144;
  localparam int unsigned OutTdataW = 40;

  // CSR addresses
  localparam logic [AddrW-1:0] CsrMvendorid  = 12'hF11;
  localparam logic [AddrW-1:0] CsrMarchid    = 12'hF12;
  localparam logic [AddrW-1:0] CsrMimpid     = 12'hF13;
  localparam logic [AddrW-1:0] CsrMhartid    = 12'hF14;
  localparam logic [AddrW-1:0] CsrMconfigptr = 12'hF15;
  localparam logic [AddrW-1:0] CsrMstatus    = 12'h300;
  localparam logic [AddrW-1:0] CsrMisa       = 12'h301;
  localparam logic [AddrW-1:0] CsrMie        = 12'h304;
  localparam logic [AddrW-1:0] CsrMtvec      = 12'h305;
  localparam logic [AddrW-1:0] CsrMstatush   = 12'h310;
  localparam logic [AddrW-1:0] CsrMscratch   = 12'h340;
  localparam logic [AddrW-1:0] CsrMepc       = 12'h341;
  localparam logic [AddrW-1:0] CsrMcause     = 12'h342;
  localparam logic [AddrW-1:0] CsrMtval      = 12'h343;
  localparam logic [AddrW-1:0] CsrMip        = 12'h344;

  // Legalization masks
  localparam logic [XLen-1:0] StatusKeep  = 32'h0000_1888;
  localparam logic [XLen-1:0] StatusMpp   = 32'h0000_1800;
  localparam logic [XLen-1:0] EnableKeep  = 32'h0000_0888;
  localparam logic [XLen-1:0] VectorClear = 32'h0000_0002;
  localparam logic [XLen-1:0] EpcClear    = 32'h0000_0003;
  localparam logic [XLen-1:0] IsaReset    = 32'h4000_0100;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgVendorId   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgArchId     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgImplId     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgHartId     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgConfigPtr  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgIsaWord    = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgStatusHigh = 3'd6;

  // One access; last member sits in the lowest bits
  typedef struct packed {
    logic [XLen-1:0]  pending_interrupts;
    logic             machine_mode;
    logic [XLen-1:0]  wr_data;
    logic [XLen-1:0]  wr_mask;
    logic [XLen-1:0]  rd_mask;
    logic [AddrW-1:0] csr_address;
  } csr_access_t;

  typedef struct packed {
    logic            ok;
    logic [XLen-1:0] rd_data;
  } csr_result_t;

  localparam int unsigned AccessW = $bits(csr_access_t);
  localparam int unsigned ResultW = $bits(csr_result_t);

  // Replace the bits under the write mask
  function automatic logic [XLen-1:0] merge_bits(logic [XLen-1:0] old_val,
                                                 logic [XLen-1:0] wmask,
                                                 logic [XLen-1:0] wdata);
    return (old_val & ~wmask) | (wdata & wmask);
  endfunction

endpackage

// ===== rtl/core/mcsr_regs.sv =====
// ----------------------------------------------------------------------------
// Machine CSR register bank
// Holds the CSR state and identity values, decodes one access per cycle.
// ----------------------------------------------------------------------------
module mcsr_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mcsr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mcsr_pkg::XLen-1:0]     cfg_wdata_i,
  input  logic                          req_valid_i,
  input  mcsr_pkg::csr_access_t         req_i,
  output mcsr_pkg::csr_result_t         rsp_o
);
  import mcsr_pkg::*;

  logic [XLen-1:0]    vendor_id_q, arch_id_q, impl_id_q, hart_id_q;
  logic [XLen-1:0]    config_ptr_q, isa_word_q, status_high_q;
  logic [StatusW-1:0] status_q, status_d;
  logic [EnableW-1:0] enable_q, enable_d;
  logic [XLen-1:0]    tvec_q, tvec_d, scratch_q, scratch_d;
  logic [XLen-1:0]    epc_q, epc_d, cause_q, cause_d, tval_q, tval_d;

  logic [XLen-1:0] old_val;
  logic [XLen-1:0] wr_val;
  logic [XLen-1:0] status_legal;
  logic            hit;
  logic            ident;
  logic            ok;
  logic            wr_en;

  // Decode address and select old value
  always_comb begin
    old_val = '0;
    hit     = 1'b1;
    ident   = 1'b0;
    unique case (req_i.csr_address)
      CsrMvendorid:  begin old_val = vendor_id_q;  ident = 1'b1; end
      CsrMarchid:    begin old_val = arch_id_q;    ident = 1'b1; end
      CsrMimpid:     begin old_val = impl_id_q;    ident = 1'b1; end
      CsrMhartid:    begin old_val = hart_id_q;    ident = 1'b1; end
      CsrMconfigptr: begin old_val = config_ptr_q; ident = 1'b1; end
      CsrMisa:       begin old_val = isa_word_q;   ident = 1'b1; end
      CsrMstatus:    old_val = {{(XLen-StatusW){1'b0}}, status_q};
      CsrMie:        old_val = {{(XLen-EnableW){1'b0}}, enable_q};
      CsrMtvec:      old_val = tvec_q;
      CsrMstatush:   old_val = status_high_q;
      CsrMscratch:   old_val = scratch_q;
      CsrMepc:       old_val = epc_q;
      CsrMcause:     old_val = cause_q;
      CsrMtval:      old_val = tval_q;
      CsrMip:        old_val = req_i.pending_interrupts;
      default:       hit = 1'b0;
    endcase
  end

  // Identity registers refuse any write bit
  assign ok = req_i.machine_mode & hit & ~(ident & (|req_i.wr_mask));
  assign rsp_o.ok      = ok;
  assign rsp_o.rd_data = ok ? (old_val & req_i.rd_mask) : '0;

  assign wr_val = merge_bits(old_val, req_i.wr_mask, req_i.wr_data);
  assign wr_en  = req_valid_i & req_i.machine_mode;

  // Keep MPP, MPIE, MIE; a nonzero MPP becomes machine mode
  always_comb begin
    status_legal = wr_val & StatusKeep;
    if (|(status_legal & StatusMpp)) begin
      status_legal = status_legal | StatusMpp;
    end
  end

  // Next state of the writable registers
  always_comb begin
    status_d  = status_q;
    enable_d  = enable_q;
    tvec_d    = tvec_q;
    scratch_d = scratch_q;
    epc_d     = epc_q;
    cause_d   = cause_q;
    tval_d    = tval_q;
    if (wr_en) begin
      unique case (req_i.csr_address)
        CsrMstatus:  status_d  = status_legal[StatusW-1:0];
        CsrMie:      enable_d  = wr_val[EnableW-1:0] & EnableKeep[EnableW-1:0];
        CsrMtvec:    tvec_d    = wr_val & ~VectorClear;
        CsrMscratch: scratch_d = wr_val;
        CsrMepc:     epc_d     = wr_val & ~EpcClear;
        CsrMcause:   cause_d   = wr_val;
        CsrMtval:    tval_d    = wr_val;
        default:     ;
      endcase
    end
  end

  // Hold CSR state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q  <= '0;
      enable_q  <= '0;
      tvec_q    <= '0;
      scratch_q <= '0;
      epc_q     <= '0;
      cause_q   <= '0;
      tval_q    <= '0;
    end else begin
      status_q  <= status_d;
      enable_q  <= enable_d;
      tvec_q    <= tvec_d;
      scratch_q <= scratch_d;
      epc_q     <= epc_d;
      cause_q   <= cause_d;
      tval_q    <= tval_d;
    end
  end

  // Take configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vendor_id_q   <= '0;
      arch_id_q     <= '0;
      impl_id_q     <= '0;
      hart_id_q     <= '0;
      config_ptr_q  <= '0;
      isa_word_q    <= IsaReset;
      status_high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgVendorId:   vendor_id_q   <= cfg_wdata_i;
        CfgArchId:     arch_id_q     <= cfg_wdata_i;
        CfgImplId:     impl_id_q     <= cfg_wdata_i;
        CfgHartId:     hart_id_q     <= cfg_wdata_i;
        CfgConfigPtr:  config_ptr_q  <= cfg_wdata_i;
        CfgIsaWord:    isa_word_q    <= cfg_wdata_i;
        CfgStatusHigh: status_high_q <= cfg_wdata_i;
        default:       ;
      endcase
    end
  end

endmodule

// ===== rtl/core/machine_csr_file.sv =====
// ----------------------------------------------------------------------------
// machine_csr_file: RV32 machine-mode CSR file
// Path: input register, then one register bank read-modify-write stage,
// then result register. Throughput: one access per cycle unless output stalls.
// Reset: asynchronous, active low; CSRs clear, ISA word returns to RV32I.
// ----------------------------------------------------------------------------
`include "machine_csr_file_assert.svh"

module machine_csr_file (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Fields from bit 0: csr_address, rd_mask, wr_mask, wr_data,
  // machine_mode, pending_interrupts, zero fill
  input  logic [mcsr_pkg::InTdataW-1:0]   s_axis_tdata,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // Fields from bit 0: rd_data, ok, zero fill
  output logic [mcsr_pkg::OutTdataW-1:0]  m_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic                            cfg_we_i,
  input  logic [mcsr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [mcsr_pkg::XLen-1:0]       cfg_wdata_i
);
  import mcsr_pkg::*;

  localparam int unsigned OutPadW = OutTdataW - ResultW;

  csr_access_t acc_q;
  csr_result_t res_q;
  csr_result_t rsp;
  logic        in_valid_q;
  logic        out_valid_q;
  logic        out_free;
  logic        advance;
  logic        in_fire;

  assign out_free      = ~out_valid_q | m_axis_tready;
  assign advance       = in_valid_q & out_free;
  assign s_axis_tready = ~in_valid_q | out_free;
  assign in_fire       = s_axis_tvalid & s_axis_tready;

  // Input register: capture a transaction when the stage is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      acc_q <= csr_access_t'(s_axis_tdata[AccessW-1:0]);
    end
  end

  // Register bank: decode and update as the access advances
  mcsr_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_valid_i (advance),
    .req_i       (acc_q),
    .rsp_o       (rsp)
  );

  // Result register: hold until the output transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= rsp;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OutPadW{1'b0}}, res_q};

  // Checks
  `MCSR_ASSERT(a_fail_reads_zero, clk_i, rst_ni, !out_valid_q || res_q.ok || res_q.rd_data == '0)
  `MCSR_ASSERT_NEXT(a_accept_loads_stage, clk_i, rst_ni, in_fire, in_valid_q)
  `MCSR_ASSERT_NEXT(a_advance_gives_result, clk_i, rst_ni, advance, out_valid_q)

endmodule

// ===== bench/tb_machine_csr_file.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Machine CSR file testbench
// Streams CSR accesses into the block and keeps a shadow copy of every
// register. Each result is checked for read data and ok, in order.
// Identity values are reloaded between phases, and both stream sides stall
// at random.
// ----------------------------------------------------------------------------
module tb_machine_csr_file;
  import mcsr_pkg::*;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic [InTdataW-1:0]   s_axis_tdata  = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OutTdataW-1:0]  m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]    cfg_idx_i     = '0;
  logic [XLen-1:0]       cfg_wdata_i   = '0;

  // Shadow identity values and writable CSRs
  logic [XLen-1:0]    id_vendor   = '0;
  logic [XLen-1:0]    id_arch     = '0;
  logic [XLen-1:0]    id_impl     = '0;
  logic [XLen-1:0]    id_hart     = '0;
  logic [XLen-1:0]    id_cfgptr   = '0;
  logic [XLen-1:0]    isa_val     = IsaReset;
  logic [XLen-1:0]    statush_val = '0;
  logic [StatusW-1:0] mstatus_q   = '0;
  logic [EnableW-1:0] mie_q       = '0;
  logic [XLen-1:0]    mtvec_q     = '0;
  logic [XLen-1:0]    mscratch_q  = '0;
  logic [XLen-1:0]    mepc_q      = '0;
  logic [XLen-1:0]    mcause_q    = '0;
  logic [XLen-1:0]    mtval_q     = '0;

  csr_result_t shadow_results[$];
  bit          idle_en     = 1'b0;
  int          rx_hold     = 0;
  int          n_errors    = 0;
  int          n_accesses  = 0;
  int          n_granted   = 0;
  int          n_results   = 0;
  int          n_cfg_loads = 0;

  machine_csr_file u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),   // csr_address, rd_mask, wr_mask,
                                     // wr_data, machine_mode,
                                     // pending_interrupts, zero fill
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // rd_data, ok, zero fill
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // Apply one access to the shadow registers and return its result
  function automatic csr_result_t shadow_csr_access(csr_access_t a);
    logic [XLen-1:0] old_val;
    logic [XLen-1:0] merged;
    logic            ok;
    logic            ident;
    csr_result_t     r;
    old_val = '0;
    ok      = 1'b0;
    ident   = 1'b0;
    if (a.machine_mode) begin
      ok = 1'b1;
      case (a.csr_address)
        CsrMvendorid:  begin old_val = id_vendor; ident = 1'b1; end
        CsrMarchid:    begin old_val = id_arch;   ident = 1'b1; end
        CsrMimpid:     begin old_val = id_impl;   ident = 1'b1; end
        CsrMhartid:    begin old_val = id_hart;   ident = 1'b1; end
        CsrMconfigptr: begin old_val = id_cfgptr; ident = 1'b1; end
        CsrMisa:       begin old_val = isa_val;   ident = 1'b1; end
        CsrMstatus:    old_val = XLen'(mstatus_q);
        CsrMie:        old_val = XLen'(mie_q);
        CsrMtvec:      old_val = mtvec_q;
        CsrMstatush:   old_val = statush_val;
        CsrMscratch:   old_val = mscratch_q;
        CsrMepc:       old_val = mepc_q;
        CsrMcause:     old_val = mcause_q;
        CsrMtval:      old_val = mtval_q;
        CsrMip:        old_val = a.pending_interrupts;
        default:       ok = 1'b0;
      endcase
      if (ident && a.wr_mask != '0) ok = 1'b0;
    end
    // Write back the masked value, legalized per register
    merged = (old_val & ~a.wr_mask) | (a.wr_data & a.wr_mask);
    if (ok) begin
      case (a.csr_address)
        CsrMstatus: begin
          merged = merged & StatusKeep;
          if ((merged & StatusMpp) != '0) merged = merged | StatusMpp;
          mstatus_q = merged[StatusW-1:0];
        end
        CsrMie:      mie_q      = merged[EnableW-1:0] & EnableKeep[EnableW-1:0];
        CsrMtvec:    mtvec_q    = merged & ~VectorClear;
        CsrMscratch: mscratch_q = merged;
        CsrMepc:     mepc_q     = merged & ~EpcClear;
        CsrMcause:   mcause_q   = merged;
        CsrMtval:    mtval_q    = merged;
        default: ;
      endcase
    end
    r.ok      = ok;
    r.rd_data = ok ? (old_val & a.rd_mask) : '0;
    return r;
  endfunction

  function automatic csr_access_t mk_access(logic [AddrW-1:0] addr, logic [XLen-1:0] rmask,
                                            logic [XLen-1:0] wmask, logic [XLen-1:0] wdata,
                                            logic mmode, logic [XLen-1:0] pend);
    csr_access_t a;
    a.csr_address        = addr;
    a.rd_mask            = rmask;
    a.wr_mask            = wmask;
    a.wr_data            = wdata;
    a.machine_mode       = mmode;
    a.pending_interrupts = pend;
    return a;
  endfunction

  function automatic logic [AddrW-1:0] pick_csr(int sel);
    case (sel)
      0:       return CsrMvendorid;
      1:       return CsrMarchid;
      2:       return CsrMimpid;
      3:       return CsrMhartid;
      4:       return CsrMconfigptr;
      5:       return CsrMisa;
      6:       return CsrMstatus;
      7:       return CsrMie;
      8:       return CsrMtvec;
      9:       return CsrMstatush;
      10:      return CsrMscratch;
      11:      return CsrMepc;
      12:      return CsrMcause;
      13:      return CsrMtval;
      default: return CsrMip;
    endcase
  endfunction

  function automatic logic [XLen-1:0] rand_mask();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // Mostly known CSRs in machine mode; the rest is noise
  function automatic csr_access_t rand_access();
    csr_access_t a;
    a.csr_address        = ($urandom_range(0, 9) < 8) ? pick_csr($urandom_range(0, 14))
                                                      : AddrW'($urandom);
    a.rd_mask            = rand_mask();
    a.wr_mask            = $urandom_range(0, 1) ? '0 : rand_mask();
    a.wr_data            = $urandom;
    a.machine_mode       = ($urandom_range(0, 9) != 0);
    a.pending_interrupts = $urandom;
    return a;
  endfunction

  // Hold each access until the block takes it
  task automatic send_access(csr_access_t a);
    int gap;
    gap = idle_en ? $urandom_range(0, 15) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InTdataW - AccessW){1'b0}}, a};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (shadow_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [XLen-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CfgVendorId:   id_vendor   = val;
      CfgArchId:     id_arch     = val;
      CfgImplId:     id_impl     = val;
      CfgHartId:     id_hart     = val;
      CfgConfigPtr:  id_cfgptr   = val;
      CfgIsaWord:    isa_val     = val;
      CfgStatusHigh: statush_val = val;
      default: ;
    endcase
  endtask

  // Reload every identity value: 0 all zeros, 1 all ones, else random
  task automatic load_identity(int profile);
    logic [XLen-1:0] v;
    n_cfg_loads++;
    for (int i = 0; i <= int'(CfgStatusHigh); i++) begin
      v = (profile == 0) ? '0 : (profile == 1) ? '1 : $urandom;
      write_cfg(CfgIdxW'(i), v);
    end
  endtask

  task automatic test_reset_state();
    send_access(mk_access(CsrMisa, '1, '0, '0, 1'b1, '0));
    send_access(mk_access(CsrMvendorid, '1, '0, '1, 1'b1, '0));
    send_access(mk_access(CsrMip, '1, '1, '1, 1'b1, '1));
    drain_results();
  endtask

  task automatic test_identity_regs();
    write_cfg(CfgVendorId, '1);
    write_cfg(CfgArchId, '0);
    write_cfg(CfgImplId, 32'h8000_0001);
    write_cfg(CfgHartId, 32'h0000_0001);
    write_cfg(CfgConfigPtr, 32'h8000_0000);
    write_cfg(CfgIsaWord, 32'h4010_1105);
    write_cfg(CfgStatusHigh, '1);
    send_access(mk_access(CsrMvendorid, '1, '0, '0, 1'b1, '0));
    send_access(mk_access(CsrMarchid, '1, '0, '0, 1'b1, '0));
    send_access(mk_access(CsrMimpid, '1, '0, '0, 1'b1, '0));
    send_access(mk_access(CsrMhartid, '1, '0, '0, 1'b1, '0));
    send_access(mk_access(CsrMconfigptr, '1, '0, '0, 1'b1, '0));
    send_access(mk_access(CsrMisa, 32'hFFFF_0000, '0, '0, 1'b1, '0));
    send_access(mk_access(CsrMstatush, '1, '0, '0, 1'b1, '0));
    // Writes to identity registers are refused; upper status ignores them
    send_access(mk_access(CsrMarchid, '1, 32'h1, '1, 1'b1, '0));
    send_access(mk_access(CsrMstatush, '1, '1, '0, 1'b1, '0));
    drain_results();
  endtask

  task automatic test_status_legalize();
    send_access(mk_access(CsrMstatus, '1, '1, '1, 1'b1, '0));
    // MPP written as 01 must read back as 11
    send_access(mk_access(CsrMstatus, '1, '1, 32'h0000_0800, 1'b1, '0));
    send_access(mk_access(CsrMstatus, '1, '0, '0, 1'b1, '0));
    send_access(mk_access(CsrMie, '1, '1, '1, 1'b1, '0));
    send_access(mk_access(CsrMie, '1, '0, '0, 1'b1, '0));
    send_access(mk_access(CsrMtvec, '1, '1, '1, 1'b1, '0));
    send_access(mk_access(CsrMtvec, '1, '1, '0, 1'b1, '0));
    send_access(mk_access(CsrMepc, '1, '1, '1, 1'b1, '0));
    send_access(mk_access(CsrMepc, '1, '0, '0, 1'b1, '0));
    drain_results();
  endtask

  task automatic test_access_faults();
    send_access(mk_access(CsrMscratch, '1, '1, '1, 1'b0, '1));
    send_access(mk_access(12'h000, '1, '1, '1, 1'b1, '0));
    send_access(mk_access(12'hFFF, '1, '0, '0, 1'b1, '0));
    send_access(mk_access(CsrMvendorid, '0, '0, '0, 1'b1, '0));
    drain_results();
  endtask

  task automatic test_random_traffic(int n_items, int profile, bit with_idle);
    load_identity(profile);
    idle_en = with_idle;
    for (int i = 0; i < n_items; i++) begin
      send_access(rand_access());
      // Stop sending now and then until the pipeline is empty
      if (i % 97 == 96) drain_results();
    end
    drain_results();
  endtask

  // Receiver: drop tready for the drawn number of cycles after each result
  always @(negedge clk_i) begin
    if (rx_hold != 0) begin
      m_axis_tready <= 1'b0;
      rx_hold--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Check each result against the oldest prediction, then predict new accesses
  always @(posedge clk_i) begin
    csr_result_t got;
    csr_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got     = csr_result_t'(m_axis_tdata[ResultW-1:0]);
        rx_hold = idle_en ? $urandom_range(0, 15) : 0;
        n_results++;
        if (shadow_results.size() == 0) begin
          $error("result with no access outstanding: ok %0b rd_data %h",
                 got.ok, got.rd_data);
          n_errors++;
        end else begin
          want = shadow_results.pop_front();
          if (got.rd_data !== want.rd_data) begin
            $error("rd_data: expected %h, actual %h", want.rd_data, got.rd_data);
            n_errors++;
          end
          if (got.ok !== want.ok) begin
            $error("ok: expected %0b, actual %0b", want.ok, got.ok);
            n_errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = shadow_csr_access(csr_access_t'(s_axis_tdata[AccessW-1:0]));
        n_accesses++;
        if (want.ok) n_granted++;
        shadow_results.push_back(want);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_identity_regs();
    test_status_legalize();
    test_access_faults();
    test_random_traffic(250, 0, 1'b0);
    test_random_traffic(300, 1, 1'b1);
    test_random_traffic(300, 2, 1'b1);
    test_random_traffic(250, 2, 1'b1);
    // Wait out anything still in flight
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    for (int k = 0; k < 2000 && shadow_results.size() != 0; k++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (shadow_results.size() != 0) begin
      $error("%0d expected results never arrived", shadow_results.size());
      n_errors += shadow_results.size();
    end
    $display("Sent %0d CSR accesses (%0d granted, %0d refused), checked %0d results.",
             n_accesses, n_granted, n_accesses - n_granted, n_results);
    $display("Identity values reloaded %0d times; stalls on both stream sides.",
             n_cfg_loads);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
